@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files of this project.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define CTPT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define CTPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ctpt_pkg.sv @@
// Package for the color track position tracker.
// Holds the color codes and the fixed classification thresholds; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctpt_pkg;

  typedef enum logic [1:0] {
    COL_BLACK = 2'd0,
    COL_WHITE = 2'd1,
    COL_BLUE  = 2'd2
  } color_t;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned COUNT_BITS  = 8;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  // White: all three channels above these.
  localparam sample_t WHITE_RED_MIN   = 10'd120;
  localparam sample_t WHITE_GREEN_MIN = 10'd240;
  localparam sample_t WHITE_BLUE_MIN  = 10'd280;

  // Blue: red strictly inside a window, green and blue above these.
  localparam sample_t BLUE_RED_LOW    = 10'd40;
  localparam sample_t BLUE_RED_HIGH   = 10'd70;
  localparam sample_t BLUE_GREEN_MIN  = 10'd140;
  localparam sample_t BLUE_BLUE_MIN   = 10'd180;

  // Black: red at most this, green and blue below these.
  localparam sample_t BLACK_RED_MAX   = 10'd30;
  localparam sample_t BLACK_GREEN_MAX = 10'd50;
  localparam sample_t BLACK_BLUE_MAX  = 10'd50;

  localparam count_t DEBOUNCE_RESET = 8'd5;

endpackage

`default_nettype wire

@@ design/color_track_position_tracker.sv @@
// Top level of the color track position tracker: classification, debounce,
// position stepping and the result register. Depends on ctpt_pkg.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+--------------------------------------
//   sample   | sample_valid/sample_stall | red_raw, green_raw, blue_raw
//   result   | result_valid/result_stall | accepted_color, travel_left,
//            |                           | cell_position, position_changed,
//            |                           | position_forced
//   config   | cfg_valid/cfg_ready       | debounce_count
//
// Every sample item yields exactly one result item in the cycle after it is accepted.
// A new sample can be taken in every cycle; the only limit is the single result
// register, so sample_stall is high only while a result waits and result_stall is high.
// Reset (rst, synchronous) resets all tracking state and the debounce limit to 5. The
// always-ready config channel must be written only while idle, unchecked by the block.
`timescale 1ns / 1ps
`default_nettype none

module color_track_position_tracker #(
  parameter int POSITION_BITS = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Sample channel.
  input  wire logic                            sample_valid,
  output logic                                 sample_stall,
  input  wire logic [9:0]                      red_raw,
  input  wire logic [9:0]                      green_raw,
  input  wire logic [9:0]                      blue_raw,
  // Result channel.
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic [1:0]                           accepted_color,
  output logic                                 travel_left,
  output logic signed [POSITION_BITS-1:0]      cell_position,
  output logic                                 position_changed,
  output logic                                 position_forced,
  // Configuration channel.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [7:0]                      debounce_count
);

  import ctpt_pkg::*;

  // Saturation bounds of the signed position.
  localparam logic signed [POSITION_BITS-1:0] PosMax =
    {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [POSITION_BITS-1:0] PosMin =
    {1'b1, {(POSITION_BITS-1){1'b0}}};
  localparam logic signed [POSITION_BITS-1:0] PosOne =
    {{(POSITION_BITS-1){1'b0}}, 1'b1};

  // Tracking state.
  count_t                          debounce_limit;
  color_t                          current_color;
  color_t                          candidate;
  count_t                          remaining;
  logic                            direction_left;
  logic signed [POSITION_BITS-1:0] position;

  // Next values.
  color_t                          sample_color;
  color_t                          accept_color;
  color_t                          candidate_next;
  count_t                          remaining_next;
  logic                            direction_left_next;
  logic signed [POSITION_BITS-1:0] position_stepped;
  logic signed [POSITION_BITS-1:0] position_next;
  logic                            changed_next;
  logic                            forced_next;

  logic                            sample_take;

  // The result register frees up whenever downstream takes its item, so a new
  // sample can enter in the same cycle.
  assign sample_stall = result_valid && result_stall;
  assign sample_take  = sample_valid && !sample_stall;
  assign cfg_ready    = 1'b1;

  // Classification. The tests run white, blue, black, and a later match wins.
  // With no match the accepted color stands.
  always_comb begin
    sample_color = current_color;
    if (red_raw > WHITE_RED_MIN && green_raw > WHITE_GREEN_MIN &&
        blue_raw > WHITE_BLUE_MIN) begin
      sample_color = COL_WHITE;
    end
    if (red_raw > BLUE_RED_LOW && red_raw < BLUE_RED_HIGH &&
        green_raw > BLUE_GREEN_MIN && blue_raw > BLUE_BLUE_MIN) begin
      sample_color = COL_BLUE;
    end
    if (red_raw <= BLACK_RED_MAX && green_raw < BLACK_GREEN_MAX &&
        blue_raw < BLACK_BLUE_MAX) begin
      sample_color = COL_BLACK;
    end
  end

  // Debounce. A color differing from the candidate restarts the count; the
  // candidate is accepted on the first matching sample after the count is zero.
  always_comb begin
    candidate_next = candidate;
    remaining_next = remaining;
    accept_color   = current_color;
    if (sample_color == candidate) begin
      if (remaining == '0) begin
        accept_color = sample_color;
      end else begin
        remaining_next = remaining - 8'd1;
      end
    end else begin
      candidate_next = sample_color;
      remaining_next = debounce_limit;
    end
  end

  // Position update. An accepted change steps one cell in the travel direction,
  // saturating at the signed bounds. A change to blue reverses direction; when
  // that turns travel back rightward, a nonzero position snaps to zero.
  always_comb begin
    position_stepped = position;
    if (!direction_left) begin
      if (position != PosMax) begin
        position_stepped = position + PosOne;
      end
    end else begin
      if (position != PosMin) begin
        position_stepped = position - PosOne;
      end
    end

    changed_next        = (accept_color != current_color);
    forced_next         = 1'b0;
    position_next       = position;
    direction_left_next = direction_left;
    if (changed_next) begin
      position_next = position_stepped;
      if (accept_color == COL_BLUE) begin
        direction_left_next = !direction_left;
        if (direction_left && position_stepped != '0) begin
          position_next = '0;
          forced_next   = 1'b1;
        end
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      debounce_limit <= debounce_count;
    end
  end

  // Tracking state advances once per accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_color  <= COL_BLUE;
      candidate      <= COL_BLUE;
      remaining      <= '0;
      direction_left <= 1'b0;
      position       <= '0;
    end else if (sample_take) begin
      current_color  <= accept_color;
      candidate      <= candidate_next;
      remaining      <= remaining_next;
      direction_left <= direction_left_next;
      position       <= position_next;
    end
  end

  // Result register: valid bit under reset, payload loaded with each sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (sample_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      accepted_color   <= accept_color;
      travel_left      <= direction_left_next;
      cell_position    <= position_next;
      position_changed <= changed_next;
      position_forced  <= forced_next;
    end
  end

endmodule

`default_nettype wire

@@ design/ctpt_checker.sv @@
// Port-level checker for the color track position tracker, bound to the top level.
// Depends on ctpt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ctpt_checker #(
  parameter int POSITION_BITS = 10
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        sample_valid,
  input wire logic                        sample_stall,
  input wire logic                        result_valid,
  input wire logic                        result_stall,
  input wire logic [1:0]                  accepted_color,
  input wire logic                        travel_left,
  input wire logic signed [POSITION_BITS-1:0] cell_position,
  input wire logic                        position_changed,
  input wire logic                        position_forced
);

  import ctpt_pkg::*;

  // A held result keeps its whole payload.
  `CTPT_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable({accepted_color, travel_left, cell_position, position_changed, position_forced}), "stalled result changed")

  // A result appears only after a sample was taken in the cycle before.
  `CTPT_ASSERT(a_result_source, $rose(result_valid), $past(sample_valid && !sample_stall), "result without a sample")

  // A forced zero only happens on an accepted change to blue turning rightward.
  `CTPT_ASSERT(a_forced_shape, result_valid && position_forced, position_changed && accepted_color == COL_BLUE && !travel_left && cell_position == '0, "forced result inconsistent")

  // Without an accepted change, consecutive results keep position and direction.
  `CTPT_ASSERT_NEXT(a_no_change_keeps, result_valid && !result_stall, !(result_valid && !position_changed) || (cell_position == $past(cell_position) && travel_left == $past(travel_left)), "position moved without a change")

endmodule

bind color_track_position_tracker ctpt_checker #(
  .POSITION_BITS(POSITION_BITS)
) u_ctpt_checker (
  .clk              (clk),
  .rst              (rst),
  .sample_valid     (sample_valid),
  .sample_stall     (sample_stall),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .accepted_color   (accepted_color),
  .travel_left      (travel_left),
  .cell_position    (cell_position),
  .position_changed (position_changed),
  .position_forced  (position_forced)
);

`default_nettype wire

@@ test/color_track_position_tracker_tb.sv @@
// Self-checking testbench for color_track_position_tracker: random and directed RGB samples,
// a per-sample predictor of the color debounce and cell position, and a result checker.
// Depends on ctpt_pkg and the color_track_position_tracker RTL only.
`timescale 1ns / 1ps

module color_track_position_tracker_tb;
  import ctpt_pkg::*;

  localparam int POS_BITS = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

  // One raw sensor sample as it travels on the sample channel.
  typedef struct packed {
    sample_t red;
    sample_t green;
    sample_t blue;
  } rgb_item_t;

  // One tracker result as the block should report it.
  typedef struct {
    color_t                     color;
    logic                       left;
    logic signed [POS_BITS-1:0] pos;
    logic                       changed;
    logic                       forced;
  } track_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic [9:0]                 red_raw = '0;
  logic [9:0]                 green_raw = '0;
  logic [9:0]                 blue_raw = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [1:0]                 accepted_color;
  logic                       travel_left;
  logic signed [POS_BITS-1:0] cell_position;
  logic                       position_changed;
  logic                       position_forced;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [7:0]                 debounce_count = '0;

  color_track_position_tracker #(
    .POSITION_BITS(POS_BITS)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .red_raw          (red_raw),
    .green_raw        (green_raw),
    .blue_raw         (blue_raw),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .accepted_color   (accepted_color),
    .travel_left      (travel_left),
    .cell_position    (cell_position),
    .position_changed (position_changed),
    .position_forced  (position_forced),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .debounce_count   (debounce_count)
  );

  always #1 clk = ~clk;

  // Samples waiting to be offered, and the results predicted for accepted samples.
  rgb_item_t     sample_queue[$];
  track_result_t predicted_track[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Long receiver hold-off: a one-cycle request starts a countdown in its own process.
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;

  // Shadow of the tracker state. Reset values match the block after rst.
  count_t                     trk_debounce = DEBOUNCE_RESET;
  color_t                     trk_color = COL_BLUE;
  logic                       trk_left = 1'b0;
  logic signed [POS_BITS-1:0] trk_pos = '0;
  color_t                     trk_cand = COL_BLUE;
  count_t                     trk_wait = '0;

  // Advances the shadow state by one sample and returns what the block must report.
  // Classification falls back to the accepted color when no threshold matches; the
  // three threshold tests are applied in order so a later match wins.
  function automatic track_result_t track_sample(rgb_item_t s);
    track_result_t res;
    color_t        seen;
    color_t        acc;
    seen = trk_color;
    if (s.red > WHITE_RED_MIN && s.green > WHITE_GREEN_MIN && s.blue > WHITE_BLUE_MIN)
      seen = COL_WHITE;
    if (s.red > BLUE_RED_LOW && s.red < BLUE_RED_HIGH && s.green > BLUE_GREEN_MIN &&
        s.blue > BLUE_BLUE_MIN)
      seen = COL_BLUE;
    if (s.red <= BLACK_RED_MAX && s.green < BLACK_GREEN_MAX && s.blue < BLACK_BLUE_MAX)
      seen = COL_BLACK;

    // A new candidate restarts the count; the color is taken only on the sample
    // after the count has run out.
    acc = trk_color;
    if (seen == trk_cand) begin
      if (trk_wait == 0)
        acc = seen;
      else
        trk_wait = trk_wait - 1'b1;
    end else begin
      trk_cand = seen;
      trk_wait = trk_debounce;
    end

    res.changed = 1'b0;
    res.forced  = 1'b0;
    if (acc != trk_color) begin
      res.changed = 1'b1;
      // Step one cell in the travel direction, saturating at the signed bounds.
      if (!trk_left) begin
        if (trk_pos != POS_MAX)
          trk_pos = trk_pos + 1'b1;
      end else if (trk_pos != POS_MIN) begin
        trk_pos = trk_pos - 1'b1;
      end
      // Blue reverses; turning back rightward snaps a nonzero position to zero.
      if (acc == COL_BLUE) begin
        if (!trk_left) begin
          trk_left = 1'b1;
        end else begin
          trk_left = 1'b0;
          if (trk_pos != 0) begin
            trk_pos   = '0;
            res.forced = 1'b1;
          end
        end
      end
      trk_color = acc;
    end
    res.color = trk_color;
    res.left  = trk_left;
    res.pos   = trk_pos;
    return res;
  endfunction

  // Random sample inside the threshold window of one color.
  function automatic rgb_item_t make_color_sample(color_t c);
    rgb_item_t s;
    case (c)
      COL_WHITE: begin
        s.red   = sample_t'($urandom_range(1023, 121));
        s.green = sample_t'($urandom_range(1023, 241));
        s.blue  = sample_t'($urandom_range(1023, 281));
      end
      COL_BLUE: begin
        s.red   = sample_t'($urandom_range(69, 41));
        s.green = sample_t'($urandom_range(1023, 141));
        s.blue  = sample_t'($urandom_range(1023, 181));
      end
      default: begin
        s.red   = sample_t'($urandom_range(30, 0));
        s.green = sample_t'($urandom_range(49, 0));
        s.blue  = sample_t'($urandom_range(49, 0));
      end
    endcase
    return s;
  endfunction

  // Fully random sample; most of these match no threshold and keep the current color.
  function automatic rgb_item_t make_noise_sample();
    rgb_item_t s;
    s.red   = sample_t'($urandom_range(1023, 0));
    s.green = sample_t'($urandom_range(1023, 0));
    s.blue  = sample_t'($urandom_range(1023, 0));
    return s;
  endfunction

  function automatic rgb_item_t rgb(int r, int g, int b);
    rgb_item_t s;
    s.red   = sample_t'(r);
    s.green = sample_t'(g);
    s.blue  = sample_t'(b);
    return s;
  endfunction

  task automatic push_run(color_t c, int len);
    repeat (len) sample_queue.push_back(make_color_sample(c));
  endtask

  // Mostly runs of one color of about the debounce length, often long enough to pass it,
  // with random content; the rest are short runs that get cut off and unmatched noise.
  task automatic load_random(int n_items);
    int     pushed;
    int     pick;
    int     len;
    color_t c;
    pushed = 0;
    while (pushed < n_items) begin
      pick = $urandom_range(99);
      c = color_t'($urandom_range(2));
      if (pick < 12) begin
        sample_queue.push_back(make_noise_sample());
        len = 1;
      end else begin
        if (pick < 24)
          len = $urandom_range(trk_debounce + 1, 1);
        else
          len = trk_debounce + $urandom_range(3, 1);
        push_run(c, len);
      end
      pushed += len;
    end
  endtask

  // Waits until every sample was taken and every result checked.
  task automatic wait_idle();
    while (sample_queue.size() != 0 || predicted_track.size() != 0 || sample_valid)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write on the config channel; only called while the block is idle.
  task automatic write_debounce(count_t value);
    debounce_count <= value;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    trk_debounce = value;
  endtask

  task automatic run_phase(count_t dbc, int unsigned idle, int unsigned stall, int n_items,
                           bit long_hold);
    write_debounce(dbc);
    send_idle_pct = idle;
    stall_pct     = stall;
    load_random(n_items);
    if (long_hold) begin
      hold_start <= 1'b1;
      @(posedge clk);
      hold_start <= 1'b0;
    end
    wait_idle();
  endtask

  // Sample driver. An offered item stays on the port until it is taken; the
  // predictor runs at the edge where the item is accepted.
  always @(posedge clk) begin : drive_samples
    logic took;
    took = sample_valid && !sample_stall;
    if (!rst && took) begin
      predicted_track.push_back(track_sample(sample_queue[0]));
      void'(sample_queue.pop_front());
    end
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (sample_valid && !took) begin
      // Stalled: hold valid and payload.
    end else if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      sample_valid <= 1'b1;
      red_raw      <= sample_queue[0].red;
      green_raw    <= sample_queue[0].green;
      blue_raw     <= sample_queue[0].blue;
    end else begin
      sample_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin : count_hold
    if (hold_start)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin : drive_stall
    result_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // Result checker: every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    track_result_t exp;
    if (!rst && result_valid && !result_stall) begin
      if (predicted_track.size() == 0) begin
        $display("%0t: result with no sample pending: color %0d pos %0d", $time,
                 accepted_color, cell_position);
        error_count++;
      end else begin
        exp = predicted_track.pop_front();
        if (accepted_color !== exp.color) begin
          $display("%0t: accepted_color expected %0d actual %0d", $time, exp.color,
                   accepted_color);
          error_count++;
        end
        if (travel_left !== exp.left) begin
          $display("%0t: travel_left expected %0d actual %0d", $time, exp.left, travel_left);
          error_count++;
        end
        if (cell_position !== exp.pos) begin
          $display("%0t: cell_position expected %0d actual %0d", $time, exp.pos,
                   cell_position);
          error_count++;
        end
        if (position_changed !== exp.changed) begin
          $display("%0t: position_changed expected %0d actual %0d", $time, exp.changed,
                   position_changed);
          error_count++;
        end
        if (position_forced !== exp.forced) begin
          $display("%0t: position_forced expected %0d actual %0d", $time, exp.forced,
                   position_forced);
          error_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL color_track_position_tracker");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset debounce of 5: field extremes, the edges of
    // every threshold window, and samples that just miss a window.
    sample_queue.push_back(rgb(120, 1023, 1023));   // just misses white
    sample_queue.push_back(rgb(0, 0, 0));
    sample_queue.push_back(rgb(30, 49, 49));
    sample_queue.push_back(rgb(0, 49, 0));
    sample_queue.push_back(rgb(30, 0, 49));
    sample_queue.push_back(rgb(17, 33, 2));
    sample_queue.push_back(rgb(30, 49, 49));
    sample_queue.push_back(rgb(0, 0, 0));          // black accepted here
    sample_queue.push_back(rgb(121, 241, 281));
    sample_queue.push_back(rgb(1023, 1023, 1023));
    sample_queue.push_back(rgb(121, 1023, 281));
    sample_queue.push_back(rgb(1023, 241, 1023));
    sample_queue.push_back(rgb(512, 512, 512));
    sample_queue.push_back(rgb(121, 241, 281));
    sample_queue.push_back(rgb(1023, 1023, 1023)); // white accepted here
    sample_queue.push_back(rgb(41, 141, 181));
    sample_queue.push_back(rgb(69, 1023, 1023));
    sample_queue.push_back(rgb(41, 1023, 181));
    sample_queue.push_back(rgb(69, 141, 1023));
    sample_queue.push_back(rgb(55, 500, 600));
    sample_queue.push_back(rgb(41, 141, 181));
    sample_queue.push_back(rgb(69, 1023, 1023));   // blue accepted, turns leftward
    sample_queue.push_back(rgb(40, 141, 181));     // just misses blue
    sample_queue.push_back(rgb(31, 49, 49));       // just misses black
    sample_queue.push_back(rgb(70, 1023, 1023));   // just misses blue
    wait_idle();

    // Position sweep with no debounce: walk leftward past zero into negative
    // cells, turn right so the position is forced to zero, turn with the
    // position landing on zero (no force), then walk rightward.
    write_debounce(8'd0);
    for (k = 0; k < 15; k++) push_run((k % 2) ? COL_BLACK : COL_WHITE, 2);
    push_run(COL_BLUE, 2);
    push_run(COL_WHITE, 2);
    push_run(COL_BLUE, 2);
    push_run(COL_BLACK, 2);
    push_run(COL_BLUE, 2);
    for (k = 0; k < 15; k++) push_run((k % 2) ? COL_WHITE : COL_BLACK, 2);
    push_run(COL_BLUE, 2);
    wait_idle();

    // Random phases across debounce settings and idling patterns. The first one
    // holds the receiver off for a long stretch so the block backs up.
    run_phase(8'd1, 0, 0, 60, 1'b1);
    run_phase(8'd3, 85, 0, 60, 1'b0);
    run_phase(8'd2, 0, 85, 60, 1'b0);
    run_phase(8'd4, 38, 38, 60, 1'b0);

    // Largest debounce: one run long enough to be accepted, then a run that is
    // cut off, leaving the count part way down for the next setting.
    write_debounce(8'd255);
    send_idle_pct = 38;
    stall_pct     = 38;
    push_run(COL_WHITE, 258);
    push_run(COL_BLACK, 20);
    wait_idle();

    run_phase(8'd1, 0, 0, 30, 1'b0);

    if (error_count == 0) begin
      $display("PASS color_track_position_tracker");
    end else begin
      $display("FAIL color_track_position_tracker");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/ctpt_pkg.sv
design/color_track_position_tracker.sv
design/ctpt_checker.sv
test/color_track_position_tracker_tb.sv
